[hdl/b2b_pkg.sv]
package b2b_pkg;

    localparam int  Rounds  = 12;
    localparam logic [63:0] ParamXor = 64'h0000_0000_0101_0000;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
        logic        zero;
        logic [3:0]  nbytes;
    } t_fifo_item;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
        endcase
        return r;
    endfunction

    // message schedule: round (mod 10), slot 0..15
    function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] slot);
        logic [63:0] row;
        case (rnd)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            4'd9: row = 64'h0dc3e9bf5167482a;
            default: row = 64'hfedcba9876543210;
        endcase
        return row[slot*4 +: 4];
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

[hdl/b2b_front.sv]
module b2b_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_flush,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [63:0]          i_message_word,
    input  logic [3:0]           i_bytes_valid,
    input  logic                 i_last_item,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output b2b_pkg::t_fifo_item  o_q_item
);
    import b2b_pkg::*;

    // two-entry queue
    t_fifo_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_fifo_item n_item;
    logic [3:0] nv;
    logic [63:0] mask;
    logic push;

    always_comb begin
        nv = (i_bytes_valid > 4'd8) ? 4'd8 : i_bytes_valid;
        if (!i_last_item) nv = 4'd8;
        mask = (nv == 4'd8) ? '1 : ((64'd1 << {nv[2:0], 3'b000}) - 64'd1);
        n_item.word   = i_message_word & mask;
        n_item.last   = i_last_item;
        n_item.zero   = (nv == 4'd0);
        n_item.nbytes = nv;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= n_item;
        if (!i_rst_n || i_flush) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count bad");
    a_no_underpop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop of empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_stall) else $error("full without stall");
endmodule

[hdl/b2b_back.sv]
module b2b_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_wdata,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  b2b_pkg::t_fifo_item  i_q_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_digest_word,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word
);
    import b2b_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_INIT, S_RND, S_FOLD, S_OUT} t_state;
    t_state r_state;

    t_word r_h [8];
    t_word r_m [16];
    t_word r_v [16];
    logic [6:0]  r_dlen;
    logic [4:0]  r_held;
    t_word       r_cnt;
    logic        r_final;
    logic [4:0]  r_hr;     // half-round 0..23
    logic [2:0]  r_oidx;
    t_fifo_item  r_item;

    // chain value start word: IV, word 0 mixed with the parameter word
    function automatic t_word h_init(input logic [2:0] idx, input logic [6:0] dlen);
        return (idx == 3'd0) ? (iv_word(idx) ^ ParamXor ^ {57'd0, dlen}) : iv_word(idx);
    endfunction

    logic [6:0] dsel;
    always_comb begin
        dsel = i_cfg_wdata;
        if (dsel == 7'd0) dsel = 7'd1;
        if (dsel > 7'd64) dsel = 7'd64;
    end

    // one half-round: four G functions in parallel
    t_word gv [16];
    logic [3:0] rnd;
    logic diag;
    always_comb begin
        t_word a, b, c, d, x, y;
        logic [3:0] ia, ib, ic, id;
        rnd  = (r_hr[4:1] >= 4'd10) ? r_hr[4:1] - 4'd10 : r_hr[4:1];
        diag = r_hr[0];
        for (int i = 0; i < 16; i++) gv[i] = r_v[i];
        for (int g = 0; g < 4; g++) begin
            ia = 4'(g);
            ib = diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
            ic = diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
            id = diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
            x = r_m[sigma(rnd, 4'((diag ? 8 : 0) + 2 * g))];
            y = r_m[sigma(rnd, 4'((diag ? 8 : 0) + 2 * g + 1))];
            a = r_v[ia]; b = r_v[ib]; c = r_v[ic]; d = r_v[id];
            a = a + b + x; d = rotr(d ^ a, 32);
            c = c + d;     b = rotr(b ^ c, 24);
            a = a + b + y; d = rotr(d ^ a, 16);
            c = c + d;     b = rotr(b ^ c, 63);
            gv[ia] = a; gv[ib] = b; gv[ic] = c; gv[id] = d;
        end
    end

    logic [6:0] left;
    logic [63:0] omask;
    assign left  = r_dlen - {1'b0, r_oidx, 3'b000};
    assign omask = (left >= 7'd8) ? '1 : ((64'd1 << {left[2:0], 3'b000}) - 64'd1);
    assign o_digest_word = r_h[r_oidx] & omask;
    assign o_word_index  = r_oidx;
    assign o_last_word   = (left <= 7'd8);
    assign o_valid       = (r_state == S_OUT);
    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid && !i_cfg_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dlen  <= 7'd64;
            r_held  <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= h_init(3'(i), 7'd64);
        end else if (i_cfg_we) begin
            r_dlen <= dsel;
            r_held <= '0;
            r_cnt  <= '0;
            r_state <= S_IDLE;
            for (int i = 0; i < 8; i++) r_h[i] <= h_init(3'(i), dsel);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (r_held == 5'd16 && !(i_q_item.last && i_q_item.zero)) begin
                            r_final <= 1'b0;
                            r_state <= S_INIT;
                        end else if (!i_q_item.zero) begin
                            r_m[r_held[3:0]] <= i_q_item.word;
                            r_held <= r_held + 5'd1;
                            r_cnt <= r_cnt + (i_q_item.last ?
                                     {60'd0, i_q_item.nbytes} : 64'd8);
                            if (i_q_item.last) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_held != 5'd16) begin
                        r_m[r_held[3:0]] <= '0;
                        r_held <= r_held + 5'd1;
                    end else begin
                        r_final <= 1'b1;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_v[8]  <= iv_word(3'd0);
                    r_v[9]  <= iv_word(3'd1);
                    r_v[10] <= iv_word(3'd2);
                    r_v[11] <= iv_word(3'd3);
                    r_v[12] <= iv_word(3'd4) ^ r_cnt;
                    r_v[13] <= iv_word(3'd5);
                    r_v[14] <= r_final ? ~iv_word(3'd6) : iv_word(3'd6);
                    r_v[15] <= iv_word(3'd7);
                    r_hr <= '0;
                    r_state <= S_RND;
                end
                S_RND: begin
                    for (int i = 0; i < 16; i++) r_v[i] <= gv[i];
                    r_hr <= r_hr + 5'd1;
                    if (r_hr == 5'(2 * Rounds - 1)) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i+8];
                    if (r_final) begin
                        r_oidx <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // place the held item now
                        if (!r_item.zero) begin
                            r_m[0] <= r_item.word;
                            r_held <= 5'd1;
                            r_cnt  <= r_cnt + (r_item.last ?
                                      {60'd0, r_item.nbytes} : 64'd8);
                        end else begin
                            r_held <= '0;
                        end
                        r_state <= r_item.last ? S_PAD : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (o_last_word) begin
                            r_state <= S_IDLE;
                            r_held  <= '0;
                            r_cnt   <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= h_init(3'(i), r_dlen);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 5'd16) else $error("held count out of range");
    a_out_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && !i_cfg_we |=> o_valid && $stable(r_oidx))
        else $error("digest index moved under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE) else $error("pop outside idle");
endmodule

[hdl/blake2b_hash_engine.sv]
// BLAKE2b hash engine, digest length 1..64 bytes.
// One message word per cycle enters a 2-entry queue unless it is full (o_stall);
// the back end takes the words one at a time; each compressed block runs init, 24
// half-rounds on one shared G-array and fold; the last block is zero-padded first.
// A held full block is compressed before the last one. Digest words leave one per
// cycle while the receiver does not stall. Reset: length 64, IV reloaded.
module blake2b_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_bytes_valid,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import b2b_pkg::*;

    logic       q_valid, q_pop;
    t_fifo_item q_item;

    b2b_front u_front (
        .i_clk, .i_rst_n, .i_flush(i_cfg_we),
        .i_valid, .o_stall, .i_message_word, .i_bytes_valid, .i_last_item,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    b2b_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b2b_pkg::*;

    // Signals to and from the engine
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_message_word;
    logic [3:0]  i_bytes_valid;
    logic        i_last_item;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    blake2b_hash_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_bytes_valid  (i_bytes_valid),
        .i_last_item    (i_last_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    localparam int  BlockWords   = 16;
    localparam int  CycleLimit   = 1500000;
    localparam int  SettleCycles = 80;
    localparam int  MaxReported  = 10;

    // One digest word as the engine should produce it
    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest;

    // Predictor state: own copy of chaining value, block and counters
    t_word       hash_state [8];
    t_word       msg_block  [BlockWords];
    int unsigned block_fill;
    t_word       byte_total;
    int unsigned digest_len;

    t_digest     digest_queue [$];
    int          mismatches;
    int          cycle_count;

    // Sender and receiver idle rates, percent
    int          send_idle_pct;
    int          recv_stall_pct;

    // Clock: 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_word rot_right(t_word x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Message word order per round; rows 10 and 11 repeat rows 0 and 1
    function automatic int unsigned schedule(int unsigned rnd, int unsigned slot);
        int unsigned rows [10][16];
        rows = '{
            '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
            '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
            '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
            '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
            '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
            '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
            '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
            '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
            '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
            '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
        return rows[rnd % 10][slot];
    endfunction

    task automatic mix(ref t_word v[16], input int a, input int b, input int c,
                       input int d, input t_word x, input t_word y);
        v[a] = v[a] + v[b] + x;
        v[d] = rot_right(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rot_right(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + y;
        v[d] = rot_right(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rot_right(v[b] ^ v[c], 63);
    endtask

    task automatic compress(input bit final_flag);
        t_word v [16];
        t_word m [16];
        for (int i = 0; i < 8; i++) begin
            v[i]     = hash_state[i];
            v[i + 8] = iv_word(i[2:0]);
        end
        for (int i = 0; i < 16; i++) begin
            m[i] = msg_block[i];
        end
        v[12] ^= byte_total;
        if (final_flag) begin
            v[14] = ~v[14];
        end
        for (int r = 0; r < Rounds; r++) begin
            mix(v, 0, 4, 8, 12, m[schedule(r, 0)], m[schedule(r, 1)]);
            mix(v, 1, 5, 9, 13, m[schedule(r, 2)], m[schedule(r, 3)]);
            mix(v, 2, 6, 10, 14, m[schedule(r, 4)], m[schedule(r, 5)]);
            mix(v, 3, 7, 11, 15, m[schedule(r, 6)], m[schedule(r, 7)]);
            mix(v, 0, 5, 10, 15, m[schedule(r, 8)], m[schedule(r, 9)]);
            mix(v, 1, 6, 11, 12, m[schedule(r, 10)], m[schedule(r, 11)]);
            mix(v, 2, 7, 8, 13, m[schedule(r, 12)], m[schedule(r, 13)]);
            mix(v, 3, 4, 9, 14, m[schedule(r, 14)], m[schedule(r, 15)]);
        end
        for (int i = 0; i < 8; i++) begin
            hash_state[i] ^= v[i] ^ v[i + 8];
        end
    endtask

    // Fresh chaining value for the current digest length
    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = iv_word(i[2:0]);
        end
        hash_state[0] ^= ParamXor ^ t_word'(digest_len);
        block_fill = 0;
        byte_total = '0;
    endfunction

    // Mirror of a length write: 0 clamps to 1, above 64 clamps to 64
    function automatic void model_length(logic [6:0] value);
        digest_len = (value < 1) ? 1 : ((value > 64) ? 64 : value);
        hash_restart();
    endfunction

    // Absorb one accepted word; queue the digest words on the last one
    task automatic absorb_word(t_word word, logic [3:0] nbytes, logic last);
        int unsigned nvalid;
        int unsigned nwords;
        int unsigned left;
        t_digest     exp_word;
        nvalid = last ? ((nbytes > 8) ? 8 : nbytes) : 8;
        if (nvalid > 0) begin
            if (block_fill >= BlockWords) begin
                compress(1'b0);
                block_fill = 0;
            end
            if (nvalid < 8) begin
                word &= (64'd1 << (8 * nvalid)) - 64'd1;
            end
            msg_block[block_fill] = word;
            block_fill++;
            byte_total += t_word'(nvalid);
        end
        if (last) begin
            for (int k = block_fill; k < BlockWords; k++) begin
                msg_block[k] = '0;
            end
            compress(1'b1);
            nwords = (digest_len + 7) / 8;
            for (int k = 0; k < nwords; k++) begin
                exp_word.word = hash_state[k];
                left = digest_len - 8 * k;
                if (left < 8) begin
                    exp_word.word &= (64'd1 << (8 * left)) - 64'd1;
                end
                exp_word.index = k[2:0];
                exp_word.last  = (k + 1 == nwords);
                digest_queue.push_back(exp_word);
            end
            hash_restart();
        end
    endtask

    // Send one word; the model absorbs it at the transfer edge.
    // Valid stays up after the transfer so words can follow back to back;
    // idle cycles and drain() drop it.
    task automatic send_word(t_word word, logic [3:0] nbytes, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_message_word <= word;
        i_bytes_valid  <= nbytes;
        i_last_item    <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        absorb_word(word, nbytes, last);
        @(negedge i_clk);
    endtask

    // Let everything drain, then give the engine time to go idle
    task automatic drain();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Length writes happen only with the engine idle
    task automatic write_length(logic [6:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_length(value);
    endtask

    // Random message of nwords, with a random tail size
    task automatic send_message(int unsigned nwords);
        logic [3:0] tail;
        for (int i = 0; i + 1 < nwords; i++) begin
            send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        end
        tail = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        send_word({$urandom, $urandom}, tail, 1'b1);
    endtask

    // Directed: empty message, tail sizes, block boundaries, oversize count
    task automatic test_directed();
        send_word('0, 4'd0, 1'b1);
        send_word('1, 4'd0, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 4'd1, 1'b1);
        send_word(64'hfedc_ba98_7654_3210, 4'd15, 1'b1);
        send_word('1, 4'd7, 1'b1);
        // exactly one block, then the block-boundary empty tail
        for (int i = 0; i < 15; i++) begin
            send_word({$urandom, $urandom}, 4'd0, 1'b0);
        end
        send_word('1, 4'd8, 1'b1);
        for (int i = 0; i < 16; i++) begin
            send_word({$urandom, $urandom}, 4'd8, 1'b0);
        end
        send_word('1, 4'd0, 1'b1);
    endtask

    // Lengths: extremes, clamping and a partial last word
    task automatic test_lengths();
        logic [6:0] lengths [7] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd13, 7'd32, 7'd64};
        foreach (lengths[i]) begin
            write_length(lengths[i]);
            send_message(1 + $urandom_range(3));
            send_message(17);
        end
    endtask

    // Mostly short messages, few multi-block ones, random lengths between
    task automatic test_random(int unsigned total);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(5) == 0) begin
                write_length(7'($urandom_range(127)));
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 6);
            send_message(len);
            sent += len;
        end
    endtask

    // Receiver stall and result check
    always @(negedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_digest exp_word;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReported) begin
                    $display("unexpected digest word %h idx %0d", o_digest_word, o_word_index);
                end
            end else begin
                exp_word = digest_queue.pop_front();
                if (exp_word.word !== o_digest_word || exp_word.index !== o_word_index
                        || exp_word.last !== o_last_word) begin
                    mismatches++;
                    if (mismatches <= MaxReported) begin
                        $display("digest mismatch: exp %h idx %0d last %0d, got %h idx %0d last %0d",
                                 exp_word.word, exp_word.index, exp_word.last,
                                 o_digest_word, o_word_index, o_last_word);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cycle_count    = 0;
        mismatches     = 0;
        send_idle_pct  = 12;
        recv_stall_pct = 86;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_message_word = '0;
        i_bytes_valid  = '0;
        i_last_item    = 1'b0;
        i_stall        = 1'b0;
        digest_len     = 64;
        hash_restart();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_lengths();
        test_random(60);
        drain();
        send_idle_pct  = 86;
        recv_stall_pct = 12;
        test_random(50);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(60);
        drain();

        if (mismatches == 0 && digest_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
